// ===== src/sorted_set_pred_succ_assert.svh =====
// Assertion macros shared by the sorted set design.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef SORTED_SET_PRED_SUCC_ASSERT_SVH
`define SORTED_SET_PRED_SUCC_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ssps_pkg.sv =====
package ssps_pkg;

    // Store geometry.
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    // Request codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOTFOUND  = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SHIFT_READ,
        S_SHIFT_WRITE,
        S_SUCC_READ,
        S_SUCC_CMP,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    step;
        logic    idx_inc;
        logic    wr_key;
        logic    wr_carry;
        logic    take_carry;
        logic    cnt_inc;
        logic    set_status;
        t_status status;
        logic    take_pred;
        logic    take_succ;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic at_end;
        logic empty;
        logic full;
        logic rd_lt;
        logic rd_eq;
        logic succ_avail;
        logic out_free;
    } t_stat;

endpackage

// ===== src/ssps_ram.sv =====
module ssps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ssps_ctrl.sv =====
module ssps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ssps_pkg::t_stat i_stat,
    output ssps_pkg::t_cmd  o_cmd
);

    import ssps_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_stat.at_end) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.rd_lt) begin
                    n_state = S_READ;
                end else if (i_stat.rd_eq) begin
                    if (i_stat.is_query && i_stat.succ_avail) begin
                        n_state = S_SUCC_READ;
                    end else begin
                        n_state = S_RESULT;
                    end
                end else if (i_stat.is_query || i_stat.full) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_SHIFT_READ;
                end
            end
            S_SHIFT_READ: begin
                if (i_stat.at_end) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_SHIFT_WRITE;
                end
            end
            S_SHIFT_WRITE: n_state = S_SHIFT_READ;
            S_SUCC_READ:   n_state = S_SUCC_CMP;
            S_SUCC_CMP:    n_state = S_RESULT;
            S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:       n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd        = '0;
        o_cmd.status = ST_INSERTED;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_READ: begin
                if (i_stat.at_end) begin
                    // Key lies above every stored key.
                    o_cmd.set_status = 1'b1;
                    if (i_stat.is_query) begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.status = ST_NOTFOUND;
                        end
                    end else if (i_stat.full) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.wr_key  = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                        o_cmd.status  = ST_INSERTED;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_CMP: begin
                if (i_stat.rd_lt) begin
                    o_cmd.step    = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end else if (i_stat.rd_eq) begin
                    o_cmd.set_status = 1'b1;
                    if (i_stat.is_query) begin
                        o_cmd.status    = ST_FOUND;
                        o_cmd.take_pred = 1'b1;
                        o_cmd.idx_inc   = i_stat.succ_avail;
                    end else begin
                        o_cmd.status = ST_DUPLICATE;
                    end
                end else if (i_stat.is_query) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOTFOUND;
                end else if (i_stat.full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                end else begin
                    // Place the new key and carry the displaced one upwards.
                    o_cmd.wr_key     = 1'b1;
                    o_cmd.take_carry = 1'b1;
                    o_cmd.idx_inc    = 1'b1;
                end
            end
            S_SHIFT_READ: begin
                if (i_stat.at_end) begin
                    o_cmd.wr_carry   = 1'b1;
                    o_cmd.cnt_inc    = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_INSERTED;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_SHIFT_WRITE: begin
                o_cmd.wr_carry   = 1'b1;
                o_cmd.take_carry = 1'b1;
                o_cmd.idx_inc    = 1'b1;
            end
            S_SUCC_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            S_SUCC_CMP: begin
                o_cmd.take_succ = 1'b1;
            end
            S_RESULT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/ssps_dp.sv =====
module ssps_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssps_pkg::t_cmd                      i_cmd,
    output ssps_pkg::t_stat                     o_stat,
    input  logic                                i_req_type,
    input  logic signed [ssps_pkg::KEY_W-1:0]   i_key,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [2:0]                          o_status,
    output logic                                o_has_pred,
    output logic signed [ssps_pkg::KEY_W-1:0]   o_pred_key,
    output logic                                o_has_succ,
    output logic signed [ssps_pkg::KEY_W-1:0]   o_succ_key
);

    import ssps_pkg::*;

    `include "sorted_set_pred_succ_assert.svh"

    // Working registers of the current request.
    logic                    r_req;
    logic signed [KEY_W-1:0] r_key;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_count;
    logic signed [KEY_W-1:0] r_prev;
    logic                    r_has_prev;
    logic [KEY_W-1:0]        r_carry;

    // Result being built, then the output register.
    t_status                 r_res_status;
    logic                    r_res_has_pred;
    logic signed [KEY_W-1:0] r_res_pred;
    logic                    r_res_has_succ;
    logic signed [KEY_W-1:0] r_res_succ;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic                    r_out_has_pred;
    logic signed [KEY_W-1:0] r_out_pred;
    logic                    r_out_has_succ;
    logic signed [KEY_W-1:0] r_out_succ;

    logic                    w_wr_en;
    logic [KEY_W-1:0]        w_wr_data;
    logic [KEY_W-1:0]        w_rd_data;
    logic signed [KEY_W-1:0] w_rd_key;

    // Key store: written and read at the walk index.
    assign w_wr_en   = i_cmd.wr_key | i_cmd.wr_carry;
    assign w_wr_data = i_cmd.wr_key ? r_key : r_carry;

    ssps_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx[ADDR_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_key = $signed(w_rd_data);

    // Status back to the controller.
    always_comb begin
        o_stat.is_query   = (r_req == REQ_QUERY);
        o_stat.at_end     = (r_idx == r_count);
        o_stat.empty      = (r_count == '0);
        o_stat.full       = (r_count == CNT_W'(CAPACITY));
        o_stat.rd_lt      = (w_rd_key < r_key);
        o_stat.rd_eq      = (w_rd_key == r_key);
        o_stat.succ_avail = ((r_idx + CNT_W'(1)) < r_count);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // Walk index and entry count, with the index cleared on request capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Request payload, smaller neighbour tracking and shift carry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= i_req_type;
            r_key      <= i_key;
            r_prev     <= '0;
            r_has_prev <= 1'b0;
        end else if (i_cmd.step) begin
            r_prev     <= w_rd_key;
            r_has_prev <= 1'b1;
        end
        if (i_cmd.take_carry) begin
            r_carry <= w_rd_data;
        end
    end

    // Result fields for the request in progress.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_status   <= ST_INSERTED;
            r_res_has_pred <= 1'b0;
            r_res_pred     <= '0;
            r_res_has_succ <= 1'b0;
            r_res_succ     <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_res_status <= i_cmd.status;
            end
            if (i_cmd.take_pred) begin
                r_res_has_pred <= r_has_prev;
                r_res_pred     <= r_prev;
            end
            if (i_cmd.take_succ) begin
                r_res_has_succ <= 1'b1;
                r_res_succ     <= w_rd_key;
            end
        end
    end

    // Output register: holds one result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status   <= r_res_status;
            r_out_has_pred <= r_res_has_pred;
            r_out_pred     <= r_res_pred;
            r_out_has_succ <= r_res_has_succ;
            r_out_succ     <= r_res_succ;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_has_pred  = r_out_has_pred;
    assign o_pred_key  = r_out_pred;
    assign o_has_succ  = r_out_has_succ;
    assign o_succ_key  = r_out_succ;

    // Checks on the store walk and the result register.
    `SSPS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `SSPS_ASSERT_NOW(a_write_range, w_wr_en, (r_idx <= r_count) && (r_idx < CNT_W'(CAPACITY)), "store write outside filled range")
    `SSPS_ASSERT_NEXT(a_count_step, i_cmd.cnt_inc, r_count == $past(r_count) + CNT_W'(1), "entry count did not advance by one")
    `SSPS_ASSERT_NOW(a_load_free, i_cmd.out_load, !r_out_valid || i_out_ready, "result beat overwritten before it was taken")
    `SSPS_ASSERT_NOW(a_neigh_found, r_out_valid && (r_out_status != ST_FOUND), !r_out_has_pred && !r_out_has_succ, "neighbour reported for a result that is not a hit")

endmodule

// ===== src/sorted_set_pred_succ.sv =====
// Ordered set of up to 64 distinct signed 32-bit keys with insert and neighbour query.
// Each input beat is an insert or a query and gives exactly one result beat. Keys sit
// in ascending order in a single key RAM, and the controller walks it from the bottom,
// one entry at a time (read, then compare on the registered read data). A query stops
// at the first key not below its own and, on a hit with a larger key stored, reads and
// takes that larger neighbour; an insert of a new key carries the displaced keys up one
// place each, again reading and then writing back each entry. One request is in progress
// at a time. The result sits in an output register, so a new request is taken while the
// last result waits.
// The key RAM needs no clearing after reset: entries above the count are never read.
module sorted_set_pred_succ (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_req_type,
    input  logic signed [ssps_pkg::KEY_W-1:0] i_key,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_status,
    output logic                              o_has_pred,
    output logic signed [ssps_pkg::KEY_W-1:0] o_pred_key,
    output logic                              o_has_succ,
    output logic signed [ssps_pkg::KEY_W-1:0] o_succ_key
);

    import ssps_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer for the store walk.
    ssps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Key store, comparators and result registers.
    ssps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_has_pred  (o_has_pred),
        .o_pred_key  (o_pred_key),
        .o_has_succ  (o_has_succ),
        .o_succ_key  (o_succ_key)
    );

endmodule

// ===== bench/sorted_set_pred_succ_test.sv =====
module sorted_set_pred_succ_test;

    import ssps_pkg::*;

    typedef logic signed [KEY_W-1:0] t_key;

    // One result beat as the block should present it.
    typedef struct packed {
        t_status status;
        logic    has_pred;
        t_key    pred_key;
        logic    has_succ;
        t_key    succ_key;
    } t_neighbour_result;

    localparam t_key KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam t_key KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    localparam int PHASE_ITEMS    = 445;
    localparam int PRESSURE_ITEMS = 8;
    localparam int HOLD_CYCLES    = 400;
    // Sized from the store capacity, to cover a walk over a full store.
    localparam int DRAIN_CYCLES   = 4 * CAPACITY + 40;
    localparam int CYCLE_LIMIT    = 2_000_000;

    // Mirror of the ordered store and the queue of results still owed by the block.
    class pred_succ_scoreboard;
        t_key              stored_keys[$];
        t_neighbour_result owed_results[$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        // Index of the first stored key that is not below the given key.
        function int first_not_below(t_key key);
            int i;
            for (i = 0; i < stored_keys.size(); i++) begin
                if (stored_keys[i] >= key) break;
            end
            return i;
        endfunction

        // Apply one accepted request beat to the mirror and queue its result.
        function void note_request(logic req, t_key key);
            t_neighbour_result r;
            int                pos;
            bit                hit;
            pos = first_not_below(key);
            hit = (pos < stored_keys.size()) && (stored_keys[pos] == key);
            r   = '0;
            if (req == REQ_INSERT) begin
                // A duplicate is reported even when the store is full.
                if (hit) begin
                    r.status = ST_DUPLICATE;
                end else if (stored_keys.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    stored_keys.insert(pos, key);
                    r.status = ST_INSERTED;
                end
            end else if (stored_keys.size() == 0) begin
                r.status = ST_EMPTY;
            end else if (!hit) begin
                r.status = ST_NOTFOUND;
            end else begin
                r.status = ST_FOUND;
                if (pos > 0) begin
                    r.has_pred = 1'b1;
                    r.pred_key = stored_keys[pos-1];
                end
                if (pos + 1 < stored_keys.size()) begin
                    r.has_succ = 1'b1;
                    r.succ_key = stored_keys[pos+1];
                end
            end
            owed_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40) $display("mismatch at result %0d: %s", results_seen, msg);
            mismatches++;
        endtask

        // Compare one accepted result beat with the oldest result owed.
        task check_result(logic [2:0] status, logic has_pred, t_key pred_key,
                          logic has_succ, t_key succ_key);
            t_neighbour_result want;
            results_seen++;
            if (owed_results.size() == 0) begin
                report_mismatch("result beat with no request outstanding");
                return;
            end
            want = owed_results.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, expected %s", status, want.status.name()));
            if (has_pred !== want.has_pred)
                report_mismatch($sformatf("has_pred %b, expected %b", has_pred, want.has_pred));
            if (pred_key !== want.pred_key)
                report_mismatch($sformatf("pred_key %0d, expected %0d", pred_key, want.pred_key));
            if (has_succ !== want.has_succ)
                report_mismatch($sformatf("has_succ %b, expected %b", has_succ, want.has_succ));
            if (succ_key !== want.succ_key)
                report_mismatch($sformatf("succ_key %0d, expected %0d", succ_key, want.succ_key));
        endtask
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_req_type  = REQ_INSERT;
    t_key        i_key       = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic        o_has_pred;
    t_key        o_pred_key;
    logic        o_has_succ;
    t_key        o_succ_key;

    pred_succ_scoreboard sb;
    int unsigned         sender_idle_pct = 0;
    int unsigned         recv_stall_pct  = 0;
    logic                rx_hold         = 1'b0;
    int unsigned         cycle_count     = 0;

    sorted_set_pred_succ dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_has_pred  (o_has_pred),
        .o_pred_key  (o_pred_key),
        .o_has_succ  (o_has_succ),
        .o_succ_key  (o_succ_key)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** sorted_set_pred_succ: FAILED **");
            $finish;
        end
    end

    // Result side: random stalls, forced low while a long hold-off is running.
    always @(posedge i_clk) begin
        i_out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Observe both channels on the clock edge that completes each beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_request(i_req_type, i_key);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_status, o_has_pred, o_pred_key, o_has_succ, o_succ_key);
        end
    end

    // Offer one request beat after a random idle gap and hold it until it is taken.
    task automatic send_request(logic req, t_key key);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key      <= key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic hold_receiver(int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    // Key for the next request: often stored keys or their near neighbours, so that
    // queries hit and inserts collide, with small, extreme and fully random values mixed in.
    function automatic t_key pick_key(int unsigned stored_pct);
        int unsigned roll;
        int          n;
        t_key        k;
        roll = $urandom_range(99);
        n    = sb.stored_keys.size();
        if (n != 0 && roll < stored_pct) begin
            k = sb.stored_keys[$urandom_range(n - 1)];
        end else if (n != 0 && roll < stored_pct + 15) begin
            k = sb.stored_keys[$urandom_range(n - 1)];
            k = $urandom_range(1) ? k + 1 : k - 1;
        end else if (roll < stored_pct + 30) begin
            k = $signed($urandom_range(80)) - 40;
        end else if (roll < stored_pct + 36) begin
            case ($urandom_range(3))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = '0;
                default: k = '1;
            endcase
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    task automatic run_random(int count);
        logic req;
        repeat (count) begin
            req = ($urandom_range(99) < 15) ? REQ_INSERT : REQ_QUERY;
            send_request(req, pick_key(req == REQ_INSERT ? 20 : 55));
        end
    endtask

    // Short directed sequence, starting from the empty store left by reset.
    task automatic run_directed();
        // Queries on an empty store.
        send_request(REQ_QUERY, '0);
        send_request(REQ_QUERY, KEY_MIN);
        send_request(REQ_QUERY, KEY_MAX);
        // A single stored key has no neighbours; a near miss is not found.
        send_request(REQ_INSERT, '0);
        send_request(REQ_QUERY, '0);
        send_request(REQ_QUERY, 32'sd1);
        send_request(REQ_INSERT, '0);
        // Extremes at both ends of the order.
        send_request(REQ_INSERT, KEY_MIN);
        send_request(REQ_INSERT, KEY_MAX);
        send_request(REQ_QUERY, KEY_MIN);
        send_request(REQ_QUERY, KEY_MAX);
        send_request(REQ_QUERY, '0);
        send_request(REQ_INSERT, KEY_MAX);
        // Keys either side of zero and alternating bit patterns.
        send_request(REQ_INSERT, '1);
        send_request(REQ_INSERT, 32'sd1);
        send_request(REQ_QUERY, '1);
        send_request(REQ_QUERY, 32'sd1);
        send_request(REQ_INSERT, 32'sh5555_5555);
        send_request(REQ_INSERT, 32'shAAAA_AAAA);
        send_request(REQ_QUERY, 32'shAAAA_AAAA);
        send_request(REQ_QUERY, 32'sh5555_5555);
        send_request(REQ_QUERY, 32'sh5555_5554);
    endtask

    initial begin
        sb = new;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Back to back on both sides.
        run_random(PHASE_ITEMS);

        // Receiver held off long enough for the block to fill and refuse requests.
        fork
            hold_receiver(HOLD_CYCLES);
        join_none
        run_random(PRESSURE_ITEMS);

        sender_idle_pct = 76;
        run_random(PHASE_ITEMS);

        sender_idle_pct = 0;
        recv_stall_pct  = 76;
        run_random(PHASE_ITEMS);

        sender_idle_pct = 8;
        recv_stall_pct  = 8;
        run_random(PHASE_ITEMS);

        // Drain the remaining results, then watch for any stray beat.
        i_in_valid     <= 1'b0;
        recv_stall_pct  = 0;
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
            $display("** sorted_set_pred_succ: PASSED **");
        end else begin
            $display("** sorted_set_pred_succ: FAILED **");
        end
        $finish;
    end

endmodule
